// ===== rtl/steq_pkg.sv =====
package steq_pkg;

    localparam int DEF_NUM_BANDS    = 3;
    localparam int DEF_NUM_CHANNELS = 2;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 20;
    localparam int SIG_W      = 32;              // Q23.8 signal path
    localparam int FRAC_BITS  = 8;
    localparam int COEF_FRAC  = 16;
    localparam int PROD_W     = COEF_W + SIG_W;  // 52
    localparam int ACC_W      = PROD_W + 4;      // five terms plus rounding
    localparam int NUM_REGS   = 6;
    localparam int MAX_BANDS  = NUM_REGS / 2;
    localparam int FF_W       = 3 * COEF_W;
    localparam int FB_W       = 2 * COEF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = FF_W;
    localparam int PC_W       = 3;

    localparam logic [FF_W-1:0] FF_RESET = FF_W'(65536);
    localparam logic [FB_W-1:0] FB_RESET = '0;

    typedef enum logic [2:0] {CF_B0, CF_B1, CF_B2, CF_A1, CF_A2} coef_sel_t;
    typedef enum logic [2:0] {OP_X, OP_X1, OP_X2, OP_Y1, OP_Y2} opnd_sel_t;
    typedef enum logic [1:0] {JC_NONE, JC_BAND, JC_CHAN} jmp_cond_t;

    typedef struct packed {
        logic            mul_en;
        coef_sel_t       coef;
        opnd_sel_t       opnd;
        logic            sub;       // product enters the sum negated
        logic            acc_load;
        logic            acc_add;
        logic            fin;       // close the biquad: round, saturate, shift history
        logic            chan_end;  // convert channel result to a sample
        jmp_cond_t       jcond;
        logic [PC_W-1:0] jtarget;
        logic            last;      // program ends when the jump is not taken
    } ucode_t;

    localparam logic [PC_W-1:0] PC_START = '0;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{mul_en: 1'b0, coef: CF_B0, opnd: OP_X, sub: 1'b0, acc_load: 1'b0,
              acc_add: 1'b0, fin: 1'b0, chan_end: 1'b0, jcond: JC_NONE,
              jtarget: PC_START, last: 1'b1};
        case (pc)
            3'd0:
            begin
                w.mul_en = 1'b1; w.coef = CF_B0; w.opnd = OP_X; w.last = 1'b0;
            end
            3'd1:
            begin
                w.mul_en = 1'b1; w.coef = CF_B1; w.opnd = OP_X1;
                w.acc_load = 1'b1; w.last = 1'b0;
            end
            3'd2:
            begin
                w.mul_en = 1'b1; w.coef = CF_B2; w.opnd = OP_X2;
                w.acc_add = 1'b1; w.last = 1'b0;
            end
            3'd3:
            begin
                w.mul_en = 1'b1; w.coef = CF_A1; w.opnd = OP_Y1; w.sub = 1'b1;
                w.acc_add = 1'b1; w.last = 1'b0;
            end
            3'd4:
            begin
                w.mul_en = 1'b1; w.coef = CF_A2; w.opnd = OP_Y2; w.sub = 1'b1;
                w.acc_add = 1'b1; w.last = 1'b0;
            end
            3'd5:
            begin
                w.fin = 1'b1; w.jcond = JC_BAND; w.jtarget = PC_START; w.last = 1'b0;
            end
            3'd6:
            begin
                w.chan_end = 1'b1; w.jcond = JC_CHAN; w.jtarget = PC_START; w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/stereo_three_band_biquad_eq_unit.sv =====
// Channel   Handshake               Payload
// s_axis    s_axis_tvalid/tready    tdata: left_in[15:0], right_in[31:16]
// m_axis    m_axis_tvalid/tready    tdata: left_out[15:0], right_out[31:16]
// cfg       cfg_valid/cfg_ready     cfg_index (register 0..5), cfg_data
//
// The sequencer works on one item at a time, using the single 20x32 multiplier that
// the microprogram steps through five times per biquad, plus one finish step per
// biquad and one per channel.
// Reset (rst_n, async) gives pass-through coefficients and zero history;
// cfg_ready is low while the sequencer runs.
// The next item is taken as soon as the sequencer is idle, even while a result waits
// in the output register; the sequencer holds at its last step while that register is full.
module stereo_three_band_biquad_eq_unit
    import steq_pkg::*;
#(
    parameter int NUM_BANDS    = DEF_NUM_BANDS,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // left_in[15:0], right_in[31:16]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // left_out[15:0], right_out[31:16]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HIST_ROWS = NUM_CHANNELS * NUM_BANDS;
    localparam int ROW_W     = (HIST_ROWS > 1) ? $clog2(HIST_ROWS) : 1;
    localparam int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HI_LSB    = COEF_FRAC + SIG_W - 1;

    localparam logic signed [SIG_W-1:0] CLAMP_HI = SIG_W'(32767 * 256);
    localparam logic signed [SIG_W-1:0] CLAMP_LO = -SIG_W'(32768 * 256);
    localparam logic signed [SIG_W-1:0] SIG_MAX  = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0] SIG_MIN  = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_ACC  = ACC_W'(1) <<< (COEF_FRAC - 1);

    function automatic logic signed [SIG_W-1:0] widen(input logic [SAMPLE_W-1:0] s);
        return {{(SIG_W-SAMPLE_W-FRAC_BITS){s[SAMPLE_W-1]}}, s, {FRAC_BITS{1'b0}}};
    endfunction

    // clamp to 16-bit range in Q8, then drop the fraction toward zero
    function automatic logic [SAMPLE_W-1:0] to_sample(input logic signed [SIG_W-1:0] v);
        logic signed [SIG_W-1:0] c;
        logic [SAMPLE_W-1:0]     q;
        c = (v > CLAMP_HI) ? CLAMP_HI : ((v < CLAMP_LO) ? CLAMP_LO : v);
        q = c[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        if (c[SIG_W-1] && (c[FRAC_BITS-1:0] != '0))
        begin
            q = q + SAMPLE_W'(1);
        end
        return q;
    endfunction

    logic [FF_W-1:0]          ff_reg [MAX_BANDS];
    logic [FB_W-1:0]          fb_reg [MAX_BANDS];
    logic signed [SIG_W-1:0]  hist_reg [HIST_ROWS][4];   // x1, x2, y1, y2

    logic                     busy_reg;
    logic [PC_W-1:0]          pc_reg;
    logic [BAND_W-1:0]        band_reg;
    logic [CH_W-1:0]          ch_reg;
    logic [31:0]              in_reg;
    logic signed [SIG_W-1:0]  cur_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SAMPLE_W-1:0]      left_res_reg;
    logic                     m_valid_reg;
    logic [31:0]              m_data_reg;

    ucode_t                   uw;
    logic [ROW_W-1:0]         row;
    logic [FF_W-1:0]          ff_sel;
    logic [FB_W-1:0]          fb_sel;
    logic signed [COEF_W-1:0] coef;
    logic signed [SIG_W-1:0]  opnd;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  sum;
    logic [ACC_W-HI_LSB-1:0]  sum_hi;
    logic signed [SIG_W-1:0]  y_sat;
    logic                     more_bands;
    logic                     more_ch;
    logic                     out_free;
    logic                     stall;
    logic                     step;
    logic                     res_done;
    logic                     jump;
    logic [SAMPLE_W-1:0]      conv;
    logic                     in_acc;
    logic                     cfg_hit;
    logic [1:0]               cfg_band;

    assign s_axis_tready = !busy_reg;
    assign cfg_ready     = !busy_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign in_acc   = s_axis_tvalid && !busy_reg;
    assign cfg_hit  = cfg_valid && cfg_ready && (int'(cfg_index) < NUM_REGS);
    assign cfg_band = cfg_index[CFG_IDX_W-1:1];

    always_comb
    begin
        uw         = ucode_rom(pc_reg);
        row        = ROW_W'(int'(ch_reg) * NUM_BANDS + int'(band_reg));
        ff_sel     = ff_reg[band_reg];
        fb_sel     = fb_reg[band_reg];
        more_bands = band_reg != BAND_W'(NUM_BANDS - 1);
        more_ch    = ch_reg != CH_W'(NUM_CHANNELS - 1);
        out_free   = !m_valid_reg || m_axis_tready;
        stall      = uw.chan_end && !more_ch && !out_free;
        step       = busy_reg && !stall;
        res_done   = step && uw.chan_end && !more_ch;

        case (uw.coef)
            CF_B0:   coef = ff_sel[COEF_W-1:0];
            CF_B1:   coef = ff_sel[2*COEF_W-1:COEF_W];
            CF_B2:   coef = ff_sel[3*COEF_W-1:2*COEF_W];
            CF_A1:   coef = fb_sel[COEF_W-1:0];
            CF_A2:   coef = fb_sel[2*COEF_W-1:COEF_W];
            default: coef = '0;
        endcase

        case (uw.opnd)
            OP_X:    opnd = cur_reg;
            OP_X1:   opnd = hist_reg[row][0];
            OP_X2:   opnd = hist_reg[row][1];
            OP_Y1:   opnd = hist_reg[row][2];
            OP_Y2:   opnd = hist_reg[row][3];
            default: opnd = cur_reg;
        endcase

        prod_next = PROD_W'(coef) * PROD_W'(opnd);

        term   = prod_sub_reg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
        sum    = acc_reg + term;
        sum_hi = sum[ACC_W-1:HI_LSB];
        if ((&sum_hi) || !(|sum_hi))
        begin
            y_sat = sum[HI_LSB:COEF_FRAC];
        end
        else
        begin
            y_sat = sum[ACC_W-1] ? SIG_MIN : SIG_MAX;
        end

        case (uw.jcond)
            JC_BAND: jump = more_bands;
            JC_CHAN: jump = more_ch;
            default: jump = 1'b0;
        endcase

        conv = to_sample(cur_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < MAX_BANDS; b++)
            begin
                ff_reg[b] <= FF_RESET;
                fb_reg[b] <= FB_RESET;
            end
            for (int r = 0; r < HIST_ROWS; r++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    hist_reg[r][k] <= '0;
                end
            end
            busy_reg     <= 1'b0;
            pc_reg       <= PC_START;
            band_reg     <= '0;
            ch_reg       <= '0;
            in_reg       <= '0;
            cur_reg      <= '0;
            prod_reg     <= '0;
            acc_reg      <= '0;
            left_res_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            prod_sub_reg <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                if (cfg_index[0])
                begin
                    fb_reg[cfg_band] <= cfg_data[FB_W-1:0];
                end
                else
                begin
                    ff_reg[cfg_band] <= cfg_data[FF_W-1:0];
                end
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    for (int b = 0; b < NUM_BANDS; b++)
                    begin
                        if (int'(cfg_band) == b)
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                hist_reg[c*NUM_BANDS+b][k] <= '0;
                            end
                        end
                    end
                end
            end

            if (res_done)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (in_acc)
            begin
                busy_reg <= 1'b1;
                pc_reg   <= PC_START;
                band_reg <= '0;
                ch_reg   <= '0;
                in_reg   <= s_axis_tdata;
                cur_reg  <= widen(s_axis_tdata[SAMPLE_W-1:0]);
            end
            else if (step)
            begin
                if (uw.mul_en)
                begin
                    prod_reg     <= prod_next;
                    prod_sub_reg <= uw.sub;
                end
                if (uw.acc_load)
                begin
                    acc_reg <= RND_ACC + term;
                end
                else if (uw.acc_add)
                begin
                    acc_reg <= sum;
                end

                if (uw.fin)
                begin
                    hist_reg[row][0] <= cur_reg;
                    hist_reg[row][1] <= hist_reg[row][0];
                    hist_reg[row][2] <= y_sat;
                    hist_reg[row][3] <= hist_reg[row][2];
                    cur_reg          <= y_sat;
                    if (more_bands)
                    begin
                        band_reg <= band_reg + BAND_W'(1);
                    end
                end

                if (uw.chan_end)
                begin
                    if (more_ch)
                    begin
                        left_res_reg <= conv;
                        ch_reg       <= ch_reg + CH_W'(1);
                        band_reg     <= '0;
                        cur_reg      <= widen(in_reg[2*SAMPLE_W-1:SAMPLE_W]);
                    end
                    else
                    begin
                        m_data_reg  <= (ch_reg == '0) ? {{SAMPLE_W{1'b0}}, conv}
                                                      : {conv, left_res_reg};
                    end
                end

                if (jump)
                begin
                    pc_reg <= uw.jtarget;
                end
                else if (uw.last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    pc_reg <= pc_reg + PC_W'(1);
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_out_at_end : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(busy_reg) && !busy_reg)
        else $error("result presented outside end of program");

    a_band_range : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (int'(band_reg) < NUM_BANDS) && (int'(ch_reg) < NUM_CHANNELS))
        else $error("band or channel counter out of range");

    a_start : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> busy_reg && (pc_reg == PC_START)
            && (band_reg == '0) && (ch_reg == '0))
        else $error("program did not start cleanly on accepted item");

    a_hold_full : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && m_valid_reg && !m_axis_tready && uw.chan_end && !more_ch
            |=> busy_reg && $stable(pc_reg))
        else $error("sequencer finished while output register was full");
`endif

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import steq_pkg::*;

    localparam int BANDS    = DEF_NUM_BANDS;
    localparam int CHANNELS = DEF_NUM_CHANNELS;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_FF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FB  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_FF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_FB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FB = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'(NUM_REGS + 1);

    localparam int COEF_ONE = 1 << COEF_FRAC;
    localparam int COEF_MAX = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_MIN = -(1 << (COEF_W - 1));
    localparam longint SIG_MAX = (longint'(1) <<< (SIG_W - 1)) - 1;
    localparam longint SIG_MIN = -(longint'(1) <<< (SIG_W - 1));
    localparam int OUT_MAX = 32767 * (1 << FRAC_BITS);
    localparam int OUT_MIN = -32768 * (1 << FRAC_BITS);

    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_FRAMES  = 50;
    localparam int CALM_TAIL     = 60;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_LEN      = 300;
    localparam int DRAIN_CYCLES  = 100;
    localparam int STALL_LIMIT   = 3000;

    typedef enum logic {JOB_FRAME, JOB_WRITE} job_kind_t;
    typedef enum int {SET_STABLE, SET_RESONANT, SET_RAW, SET_EXTREME, SET_FLAT} setup_t;

    typedef struct {
        job_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [FF_W-1:0]       val;
    } job_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // equalizer state as the block should hold it
    logic [FF_W-1:0] coef_reg [NUM_REGS];
    int              hist [CHANNELS][BANDS][4];   // x1, x2, y1, y2 in Q8

    job_t        jobs [$];
    logic [31:0] eq_due [$];

    int  frames_in, writes_in, results_seen, bad_results, settings_used;
    int  idle_cycles;
    bit  frame_taken, write_taken;
    int  send_gap, send_mode, send_cycle;
    int  recv_gap, recv_mode, recv_cycle, hold_left;
    bit  hold_done;

    stereo_three_band_biquad_eq_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint coef_at(logic [FF_W-1:0] word, int slot);
        logic [COEF_W-1:0] c;
        c = word[slot*COEF_W +: COEF_W];
        return longint'($signed(c));
    endfunction

    function automatic int biquad_step(int band, int ch, int x);
        logic [FF_W-1:0] ff, fb;
        longint          acc, r;
        ff = coef_reg[2*band];
        fb = coef_reg[2*band+1];
        acc = coef_at(ff, 0) * x
            + coef_at(ff, 1) * hist[ch][band][0]
            + coef_at(ff, 2) * hist[ch][band][1]
            - coef_at(fb, 0) * hist[ch][band][2]
            - coef_at(fb, 1) * hist[ch][band][3];
        r = (acc + 64'sd32768) >>> COEF_FRAC;   // round half up to Q8
        if (r > SIG_MAX)
            r = SIG_MAX;
        else if (r < SIG_MIN)
            r = SIG_MIN;
        hist[ch][band][1] = hist[ch][band][0];
        hist[ch][band][0] = x;
        hist[ch][band][3] = hist[ch][band][2];
        hist[ch][band][2] = int'(r);
        return int'(r);
    endfunction

    function automatic logic [SAMPLE_W-1:0] equalize_channel(int ch, logic [SAMPLE_W-1:0] raw);
        int v, b, q;
        v = int'($signed(raw)) * (1 << FRAC_BITS);
        for (b = 0; b < BANDS; b++)
            v = biquad_step(b, ch, v);
        if (v > OUT_MAX)
            v = OUT_MAX;
        else if (v < OUT_MIN)
            v = OUT_MIN;
        q = v / (1 << FRAC_BITS);   // signed division drops the fraction toward zero
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic logic [31:0] equalize_frame(logic [31:0] frame);
        logic [SAMPLE_W-1:0] l, r;
        l = equalize_channel(0, frame[15:0]);
        r = (CHANNELS > 1) ? equalize_channel(1, frame[31:16]) : '0;
        return {r, l};
    endfunction

    function automatic void write_coef(logic [CFG_IDX_W-1:0] idx, logic [FF_W-1:0] val);
        int band, ch, k;
        if (idx >= NUM_REGS)
            return;
        coef_reg[idx] = idx[0] ? FF_W'(val[FB_W-1:0]) : val;
        band = idx / 2;
        if (band >= BANDS)
            return;
        for (ch = 0; ch < CHANNELS; ch++)
            for (k = 0; k < 4; k++)
                hist[ch][band][k] = 0;
    endfunction

    function automatic void add_frame(int l, int r);
        job_t j;
        j.kind = JOB_FRAME;
        j.idx  = '0;
        j.val  = FF_W'({r[15:0], l[15:0]});
        jobs.push_back(j);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [FF_W-1:0] val);
        job_t j;
        j.kind = JOB_WRITE;
        j.idx  = idx;
        j.val  = val;
        jobs.push_back(j);
    endfunction

    function automatic logic [FF_W-1:0] pack_ff(int b0, int b1, int b2);
        return {20'(b2), 20'(b1), 20'(b0)};
    endfunction

    // junk above the two feedback fields checks that the block drops it
    function automatic logic [FF_W-1:0] pack_fb(int a1, int a2);
        return {20'($urandom), 20'(a2), 20'(a1)};
    endfunction

    function automatic int srange(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic int pick_coef_extreme();
        case ($urandom_range(0, 2))
            0: return COEF_MAX;
            1: return COEF_MIN;
            default: return 0;
        endcase
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 19))
            0: return 32767;
            1: return -32768;
            2: return 0;
            3: return srange(64);
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic void setup_band(int b, setup_t mode);
        logic [CFG_IDX_W-1:0] ff_idx, fb_idx;
        ff_idx = REG_LOW_FF + 3'(2 * b);
        fb_idx = REG_LOW_FB + 3'(2 * b);
        case (mode)
            SET_STABLE:
            begin
                add_write(ff_idx, pack_ff(srange(40000), srange(24000), srange(24000)));
                add_write(fb_idx, pack_fb(srange(40000), srange(20000)));
            end
            SET_RESONANT:
            begin
                // poles close to the unit circle, long ringing
                add_write(ff_idx, pack_ff(srange(3000), srange(3000), srange(3000)));
                add_write(fb_idx, pack_fb(-int'($urandom_range(100000, 115000)),
                                          int'($urandom_range(56000, 62000))));
            end
            SET_RAW:
            begin
                add_write(ff_idx, FF_W'({$urandom, $urandom}));
                add_write(fb_idx, FF_W'({$urandom, $urandom}));
            end
            SET_EXTREME:
            begin
                add_write(ff_idx, pack_ff(pick_coef_extreme(), pick_coef_extreme(),
                                          pick_coef_extreme()));
                add_write(fb_idx, pack_fb(pick_coef_extreme(), pick_coef_extreme()));
            end
            default:
            begin
                add_write(ff_idx, FF_RESET);
                add_write(fb_idx, FF_W'(FB_RESET));
            end
        endcase
    endfunction

    function automatic setup_t pick_setup();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SET_STABLE;
            4, 5:       return SET_RESONANT;
            6, 7:       return SET_RAW;
            8:          return SET_EXTREME;
            default:    return SET_FLAT;
        endcase
    endfunction

    function automatic int roll_burst(int mode);
        if (mode == 0)
            return 0;
        if ($urandom_range(0, (mode == 1) ? 11 : 3) != 0)
            return 0;
        return $urandom_range(1, 8);
    endfunction

    // accepted items and results, both seen at the rising edge
    always @(posedge clk)
    begin : sampler
        logic [31:0] want;
        bit          moved;
        moved = 0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                eq_due.push_back(equalize_frame(s_axis_tdata));
                void'(jobs.pop_front());
                frames_in++;
                frame_taken = 1;
                moved = 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_coef(cfg_index, cfg_data);
                void'(jobs.pop_front());
                writes_in++;
                write_taken = 1;
                moved = 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1;
                results_seen++;
                if (eq_due.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result %h at cycle %0d", m_axis_tdata, $time / 10);
                end
                else
                begin
                    want = eq_due.pop_front();
                    if (want[15:0] !== m_axis_tdata[15:0] || want[31:16] !== m_axis_tdata[31:16])
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("result %0d: left exp %0d got %0d, right exp %0d got %0d",
                                     results_seen, $signed(want[15:0]),
                                     $signed(m_axis_tdata[15:0]), $signed(want[31:16]),
                                     $signed(m_axis_tdata[31:16]));
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    always @(negedge clk)
    begin : driver
        bit offer_frame, offer_reg, calm;
        offer_frame = s_axis_tvalid && !frame_taken;
        offer_reg   = cfg_valid && !write_taken;
        calm        = jobs.size() <= CALM_TAIL;
        if (send_cycle % 64 == 0)
            send_mode = $urandom_range(0, 2);
        send_cycle++;
        if ((frame_taken || write_taken) && !calm)
            send_gap = roll_burst(send_mode);
        frame_taken = 0;
        write_taken = 0;
        if (rst_n && !offer_frame && !offer_reg)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (jobs.size() > 0)
            begin
                if (jobs[0].kind == JOB_FRAME)
                begin
                    offer_frame = 1;
                    s_axis_tdata <= jobs[0].val[31:0];
                end
                else if (eq_due.size() == 0)
                begin
                    // coefficients change only once every result is out
                    offer_reg = 1;
                    cfg_index <= jobs[0].idx;
                    cfg_data  <= jobs[0].val;
                end
            end
        end
        s_axis_tvalid <= offer_frame;
        cfg_valid     <= offer_reg;
    end

    always @(negedge clk)
    begin : receiver
        bit take;
        take = 1;
        if (recv_cycle % 64 == 0)
            recv_mode = $urandom_range(0, 2);
        recv_cycle++;
        if (!hold_done && frames_in >= HOLD_AT)
        begin
            // long back-pressure: output register fills and input stalls
            hold_left = HOLD_LEN;
            hold_done = 1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            take = 0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            take = 0;
        end
        else if (jobs.size() > CALM_TAIL)
        begin
            recv_gap = roll_burst(recv_mode);
            if (recv_gap > 0)
            begin
                recv_gap--;
                take = 0;
            end
        end
        m_axis_tready <= take;
    end

    initial
    begin : watchdog
        wait (rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, eq_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : run
        int p, n, b;
        for (b = 0; b < NUM_REGS; b++)
            coef_reg[b] = (b % 2 == 0) ? FF_RESET : FF_W'(FB_RESET);
        hist = '{default: '{default: '{default: 0}}};

        // pass-through straight out of reset
        add_frame(0, 0);
        add_frame(32767, -32768);
        add_frame(-32768, 32767);
        add_frame(-1, 1);
        add_frame(21845, -21846);
        // low band gain near 8: output clamps both ways
        add_write(REG_LOW_FF, pack_ff(COEF_MAX, 0, 0));
        add_write(REG_LOW_FB, pack_fb(0, 0));
        add_write(REG_PEAK_FF, FF_RESET);
        add_write(REG_PEAK_FB, FF_W'(FB_RESET));
        add_write(REG_HIGH_FF, FF_RESET);
        add_write(REG_HIGH_FB, FF_W'(FB_RESET));
        add_write(REG_SPARE_A, FF_W'({$urandom, $urandom}));
        add_write(REG_SPARE_B, FF_W'({$urandom, $urandom}));
        add_frame(32767, -32768);
        add_frame(1000, -1000);
        add_frame(-5, 5);
        // every coefficient at full scale: saturation inside the cascade
        for (b = 0; b < BANDS; b++)
        begin
            add_write(REG_LOW_FF + 3'(2 * b), pack_ff(COEF_MIN, COEF_MIN, COEF_MIN));
            add_write(REG_LOW_FB + 3'(2 * b), pack_fb(COEF_MAX, COEF_MAX));
        end
        add_frame(32767, -32768);
        add_frame(-32768, 32767);
        add_frame(32767, 32767);
        add_frame(0, 0);
        // half gain: odd samples truncate toward zero
        add_write(REG_LOW_FF, pack_ff(COEF_ONE / 2, 0, 0));
        add_write(REG_LOW_FB, pack_fb(0, 0));
        for (b = 1; b < BANDS; b++)
        begin
            add_write(REG_LOW_FF + 3'(2 * b), FF_RESET);
            add_write(REG_LOW_FB + 3'(2 * b), FF_W'(FB_RESET));
        end
        add_frame(-3, 3);
        add_frame(-1, 1);
        add_frame(32767, -32768);
        // pure feedback in the peak band: y = x + y1/2
        add_write(REG_LOW_FF, FF_RESET);
        add_write(REG_PEAK_FB, pack_fb(-COEF_ONE / 2, 0));
        add_frame(20000, -20000);
        add_frame(20000, -20000);
        add_frame(20000, -20000);
        settings_used = 5;

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            // some bands keep their history across the phase boundary
            for (b = 0; b < BANDS; b++)
                if ($urandom_range(0, 3) != 0)
                    setup_band(b, pick_setup());
            if ($urandom_range(0, 3) == 0)
                add_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          FF_W'({$urandom, $urandom}));
            for (n = 0; n < PHASE_FRAMES; n++)
                add_frame(pick_sample(), pick_sample());
            settings_used++;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (jobs.size() != 0 || eq_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d frames under %0d coefficient settings, %0d register writes",
                 frames_in, settings_used, writes_in);
        $display("%0d results checked, %0d mismatches", results_seen, bad_results);
        if (bad_results == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
